// ===== hdl/qpn_pkg.sv =====
package qpn_pkg;

  // register map, word index on the configuration port
  typedef enum logic [2:0] {
    REG_PERIOD  = 3'd0,
    REG_NOISE_W = 3'd1,
    REG_NOISE_X = 3'd2,
    REG_NOISE_Y = 3'd3,
    REG_NOISE_Z = 3'd4
  } reg_idx_t;

  localparam logic [9:0] PERIOD_RESET    = 10'd10;
  localparam int         NORM_EXTRA_BITS = 14;
  // floor(v / 125) == (v * RECIP_125) >> RECIP_SHIFT for v below 2^32.19
  localparam int          RECIP_SHIFT = 37;
  localparam logic [30:0] RECIP_125   = 31'd1099511628;
  localparam int          SQRT_STEPS  = 31;

  typedef logic [3:0][15:0] quat_t;

  typedef struct packed {
    quat_t            q;
    logic [2:0][15:0] r;
  } prop_in_t;

  typedef struct packed {
    logic [9:0] period_ms;
    quat_t      noise;
  } cfg_t;

  typedef struct packed {
    quat_t       p;
    logic [30:0] nrm;
    logic        zero;
  } norm_res_t;

  typedef struct packed {
    quat_t o;
    logic  zero;
  } qpn_res_t;

endpackage

// ===== hdl/qpn_in_if.sv =====
interface qpn_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] quat_w;
  logic [15:0] quat_x;
  logic [15:0] quat_y;
  logic [15:0] quat_z;
  logic [15:0] rate_x;
  logic [15:0] rate_y;
  logic [15:0] rate_z;
  modport source(output valid, quat_w, quat_x, quat_y, quat_z, rate_x, rate_y, rate_z,
                 input ready);
  modport sink(input valid, quat_w, quat_x, quat_y, quat_z, rate_x, rate_y, rate_z,
               output ready);
endinterface

// ===== hdl/qpn_out_if.sv =====
interface qpn_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] out_w;
  logic [15:0] out_x;
  logic [15:0] out_y;
  logic [15:0] out_z;
  logic        zero_norm;
  modport source(output valid, out_w, out_x, out_y, out_z, zero_norm, input ready);
  modport sink(input valid, out_w, out_x, out_y, out_z, zero_norm, output ready);
endinterface

// ===== hdl/qpn_prop.sv =====
module qpn_prop import qpn_pkg::*; #(
  parameter int RATE_FRAC_BITS = 10
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  prop_in_t in_data,
  input  cfg_t     cfg,
  output logic     out_valid,
  input  logic     out_ready,
  output quat_t    out_p
);

  localparam int NS = 5;
  localparam int VW = 40 - RATE_FRAC_BITS;
  localparam int IW = VW - 6;
  localparam int SW = ((IW > 16) ? IW : 16) + 2;
  localparam logic [44:0] DEN = 45'(2000) << RATE_FRAC_BITS;
  localparam logic signed [SW-1:0] S16_MAX = SW'(32767);
  localparam logic signed [SW-1:0] S16_MIN = SW'(-32768);

  logic [NS-1:0] v, en, vin;

  assign en[NS-1] = !v[NS-1] || out_ready;
  for (genvar k = 0; k < NS - 1; k++) begin : g_en
    assign en[k] = !v[k] || en[k+1];
  end
  assign vin      = {v[NS-2:0], in_valid};
  assign in_ready = en[0];
  assign out_valid = v[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int k = 0; k < NS; k++) if (en[k]) v[k] <= vin[k];
    end
  end

  // stage 0: all rate by quaternion products
  logic signed [31:0] prd [3][4];
  quat_t q0, q1, q2, q3;
  always_ff @(posedge clk) begin
    if (en[0]) begin
      q0 <= in_data.q;
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 4; j++)
          prd[i][j] <= $signed(in_data.r[i]) * $signed(in_data.q[j]);
    end
  end

  // stage 1: rows of Omega*q
  logic signed [33:0] s [4];
  always_ff @(posedge clk) begin
    if (en[1]) begin
      q1   <= q0;
      s[0] <= -prd[0][1] - prd[1][2] - prd[2][3];
      s[1] <=  prd[0][0] + prd[2][2] - prd[1][3];
      s[2] <=  prd[1][0] - prd[2][1] + prd[0][3];
      s[3] <=  prd[2][0] + prd[1][1] - prd[0][2];
    end
  end

  // stage 2: scale by period, round magnitude, drop the power-of-two part of the divisor
  logic signed [44:0] t [4];
  logic [44:0] tmag [4], xr [4];
  logic [VW-1:0] vq [4];
  logic [3:0] neg2, neg3;
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      t[i]    = s[i] * $signed({1'b0, cfg.period_ms});
      tmag[i] = t[i][44] ? 45'(-t[i]) : 45'(t[i]);
      xr[i]   = (tmag[i] << 1) + DEN;
    end
  end
  always_ff @(posedge clk) begin
    if (en[2]) begin
      q2 <= q1;
      for (int i = 0; i < 4; i++) begin
        vq[i]   <= xr[i][44:RATE_FRAC_BITS+5];
        neg2[i] <= t[i][44];
      end
    end
  end

  // stage 3: divide by 125 through the reciprocal
  logic [VW+30:0] rp [4];
  always_ff @(posedge clk) begin
    if (en[3]) begin
      q3   <= q2;
      neg3 <= neg2;
      for (int i = 0; i < 4; i++) rp[i] <= vq[i] * RECIP_125;
    end
  end

  // stage 4: add increment and noise mean, saturate
  logic [IW-1:0] incm [4];
  logic signed [SW-1:0] inc [4], sm [4];
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      incm[i] = rp[i][VW+30:RECIP_SHIFT];
      inc[i]  = neg3[i] ? -$signed({1'b0, incm[i]}) : $signed({1'b0, incm[i]});
      sm[i]   = inc[i] + $signed(q3[i]) + $signed(cfg.noise[i]);
    end
  end
  always_ff @(posedge clk) begin
    if (en[4]) begin
      for (int i = 0; i < 4; i++) begin
        if (sm[i] > S16_MAX)      out_p[i] <= 16'h7fff;
        else if (sm[i] < S16_MIN) out_p[i] <= 16'h8000;
        else                      out_p[i] <= sm[i][15:0];
      end
    end
  end

endmodule

// ===== hdl/qpn_norm.sv =====
module qpn_norm import qpn_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  quat_t     in_p,
  output logic      out_valid,
  input  logic      out_ready,
  output norm_res_t out_data
);

  localparam int NS = SQRT_STEPS + 2;

  logic [NS-1:0] v, en, vin;

  assign en[NS-1] = !v[NS-1] || out_ready;
  for (genvar k = 0; k < NS - 1; k++) begin : g_en
    assign en[k] = !v[k] || en[k+1];
  end
  assign vin       = {v[NS-2:0], in_valid};
  assign in_ready  = en[0];
  assign out_valid = v[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int k = 0; k < NS; k++) if (en[k]) v[k] <= vin[k];
    end
  end

  quat_t pp [NS];
  logic  zr [NS];
  logic signed [31:0] sq [4];
  logic [32:0] n2 [NS];
  logic [30:0] root [NS];
  logic [33:0] rem  [NS];

  // stage 0: squares
  always_ff @(posedge clk) begin
    if (en[0]) begin
      pp[0] <= in_p;
      for (int i = 0; i < 4; i++) sq[i] <= $signed(in_p[i]) * $signed(in_p[i]);
    end
  end

  // stage 1: squared norm
  always_ff @(posedge clk) begin
    if (en[1]) begin
      pp[1] <= pp[0];
      n2[1] <= 33'(sq[0][30:0]) + 33'(sq[1][30:0]) + 33'(sq[2][30:0]) + 33'(sq[3][30:0]);
      zr[1] <= (sq[0] == 0) && (sq[1] == 0) && (sq[2] == 0) && (sq[3] == 0);
      root[1] <= '0;
      rem[1]  <= '0;
    end
  end

  // one root bit per stage, two radicand bits consumed each step
  for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
    localparam int K = g + 2;
    logic [61:0] rad;
    logic [35:0] sh;
    logic [35:0] trial;
    logic        take;
    assign rad   = {1'b0, n2[K-1], (2 * NORM_EXTRA_BITS)'(0)};
    assign sh    = {rem[K-1], rad[61-2*g -: 2]};
    assign trial = {3'b000, root[K-1], 2'b01};
    assign take  = sh >= trial;
    always_ff @(posedge clk) begin
      if (en[K]) begin
        pp[K]   <= pp[K-1];
        zr[K]   <= zr[K-1];
        n2[K]   <= n2[K-1];
        root[K] <= {root[K-1][29:0], take};
        rem[K]  <= take ? 34'(sh - trial) : sh[33:0];
      end
    end
  end

  assign out_data.p    = pp[NS-1];
  assign out_data.nrm  = root[NS-1];
  assign out_data.zero = zr[NS-1];

endmodule

// ===== hdl/qpn_div.sv =====
module qpn_div import qpn_pkg::*; #(
  parameter int QUAT_FRAC_BITS = 14
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  norm_res_t in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output qpn_res_t  out_data
);

  localparam int QB = QUAT_FRAC_BITS + 2;
  localparam int NW = QUAT_FRAC_BITS + 32;
  localparam int NS = QB + 2;
  localparam logic [15:0] ONE_Q = (QUAT_FRAC_BITS >= 15) ? 16'h7fff
                                                          : 16'(1 << QUAT_FRAC_BITS);

  logic [NS-1:0] v, en, vin;

  assign en[NS-1] = !v[NS-1] || out_ready;
  for (genvar k = 0; k < NS - 1; k++) begin : g_en
    assign en[k] = !v[k] || en[k+1];
  end
  assign vin       = {v[NS-2:0], in_valid};
  assign in_ready  = en[0];
  assign out_valid = v[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int k = 0; k < NS; k++) if (en[k]) v[k] <= vin[k];
    end
  end

  logic [32:0]   remr [QB+1][4];
  logic [QB-1:0] lo   [QB+1][4];
  logic [QB-1:0] qt   [QB+1][4];
  logic [3:0]    sg   [QB+1];
  logic [31:0]   dv   [QB+1];
  logic          zr   [QB+1];

  // stage 0: rounded dividend 2*|p|*2^(Q+14) + nrm over divisor 2*nrm
  logic [15:0]   mag [4];
  logic [NW-1:0] nd  [4];
  always_comb begin
    for (int l = 0; l < 4; l++) begin
      mag[l] = in_data.p[l][15] ? 16'(-$signed(in_data.p[l])) : in_data.p[l];
      nd[l]  = (NW'(mag[l]) << (QUAT_FRAC_BITS + NORM_EXTRA_BITS + 1)) + NW'(in_data.nrm);
    end
  end
  always_ff @(posedge clk) begin
    if (en[0]) begin
      dv[0] <= {in_data.nrm, 1'b0};
      zr[0] <= in_data.zero;
      for (int l = 0; l < 4; l++) begin
        remr[0][l] <= 33'(nd[l][NW-1:QB]);
        lo[0][l]   <= nd[l][QB-1:0];
        qt[0][l]   <= '0;
        sg[0][l]   <= in_data.p[l][15];
      end
    end
  end

  // one quotient bit per stage in each lane
  for (genvar g = 1; g <= QB; g++) begin : g_div
    logic [33:0] sh [4];
    logic [3:0]  take;
    always_comb begin
      for (int l = 0; l < 4; l++) begin
        sh[l]   = {remr[g-1][l], lo[g-1][l][QB-g]};
        take[l] = sh[l] >= {2'b00, dv[g-1]};
      end
    end
    always_ff @(posedge clk) begin
      if (en[g]) begin
        dv[g] <= dv[g-1];
        zr[g] <= zr[g-1];
        sg[g] <= sg[g-1];
        for (int l = 0; l < 4; l++) begin
          lo[g][l]   <= lo[g-1][l];
          remr[g][l] <= take[l] ? 33'(sh[l] - {2'b00, dv[g-1]}) : sh[l][32:0];
          qt[g][l]   <= {qt[g-1][l][QB-2:0], take[l]};
        end
      end
    end
  end

  // last stage: sign, saturate, identity on a zero norm
  logic [31:0] qw [4];
  logic [15:0] ov [4];
  always_comb begin
    for (int l = 0; l < 4; l++) begin
      qw[l] = 32'(qt[QB][l]);
      if (!sg[QB][l]) ov[l] = (qw[l] > 32'd32767) ? 16'h7fff : qw[l][15:0];
      else            ov[l] = (qw[l] > 32'd32768) ? 16'h8000 : 16'(-qw[l]);
    end
  end
  always_ff @(posedge clk) begin
    if (en[NS-1]) begin
      out_data.zero <= zr[QB];
      for (int l = 0; l < 4; l++) begin
        if (zr[QB]) out_data.o[l] <= (l == 0) ? ONE_Q : 16'h0000;
        else        out_data.o[l] <= ov[l];
      end
    end
  end

endmodule

// ===== hdl/quaternion_propagate_normalize.sv =====
// channel   role    fields
// sample    sink    quat_w quat_x quat_y quat_z (Q1.14), rate_x rate_y rate_z (Q5.10)
// result    source  out_w out_x out_y out_z (Q1.14), zero_norm
// apb       slave   period_ms @0x00, noise_mean_w/x/y/z @0x04..0x10
//
// One item per cycle while the result side does not stall; 5 propagate stages,
// 33 norm and square-root stages (31 at one root bit each), QUAT_FRAC_BITS + 4 divide stages.
// Synchronous reset empties every stage and loads the register reset values.
// A stage holds while the next one is full and stalled; empty stages keep filling.
module quaternion_propagate_normalize import qpn_pkg::*; #(
  parameter int QUAT_FRAC_BITS = 14,
  parameter int RATE_FRAC_BITS = 10
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  qpn_in_if.sink       sample,
  qpn_out_if.source    result
);

  cfg_t cfg;
  reg_idx_t widx;

  assign pready = 1'b1;
  assign widx   = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.period_ms <= PERIOD_RESET;
      cfg.noise     <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (widx)
        REG_PERIOD:  cfg.period_ms <= pwdata[9:0];
        REG_NOISE_W: cfg.noise[0]  <= pwdata[15:0];
        REG_NOISE_X: cfg.noise[1]  <= pwdata[15:0];
        REG_NOISE_Y: cfg.noise[2]  <= pwdata[15:0];
        REG_NOISE_Z: cfg.noise[3]  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (widx)
      REG_PERIOD:  prdata = {22'd0, cfg.period_ms};
      REG_NOISE_W: prdata = 32'($signed(cfg.noise[0]));
      REG_NOISE_X: prdata = 32'($signed(cfg.noise[1]));
      REG_NOISE_Y: prdata = 32'($signed(cfg.noise[2]));
      REG_NOISE_Z: prdata = 32'($signed(cfg.noise[3]));
      default:     prdata = 32'd0;
    endcase
  end

  prop_in_t  pin;
  quat_t     pq;
  norm_res_t nres;
  qpn_res_t  res;
  logic      p_valid, p_ready, n_valid, n_ready;

  assign pin.q = {sample.quat_z, sample.quat_y, sample.quat_x, sample.quat_w};
  assign pin.r = {sample.rate_z, sample.rate_y, sample.rate_x};

  qpn_prop #(.RATE_FRAC_BITS(RATE_FRAC_BITS)) u_prop (
    .clk(clk), .rst(rst),
    .in_valid(sample.valid), .in_ready(sample.ready), .in_data(pin), .cfg(cfg),
    .out_valid(p_valid), .out_ready(p_ready), .out_p(pq)
  );

  qpn_norm u_norm (
    .clk(clk), .rst(rst),
    .in_valid(p_valid), .in_ready(p_ready), .in_p(pq),
    .out_valid(n_valid), .out_ready(n_ready), .out_data(nres)
  );

  qpn_div #(.QUAT_FRAC_BITS(QUAT_FRAC_BITS)) u_div (
    .clk(clk), .rst(rst),
    .in_valid(n_valid), .in_ready(n_ready), .in_data(nres),
    .out_valid(result.valid), .out_ready(result.ready), .out_data(res)
  );

  assign result.out_w     = res.o[0];
  assign result.out_x     = res.o[1];
  assign result.out_y     = res.o[2];
  assign result.out_z     = res.o[3];
  assign result.zero_norm = res.zero;

  // an empty output stage lets the whole pipe advance
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !result.valid |-> sample.ready)
    else $error("input stalled with an empty output stage");

  a_identity: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.zero_norm |->
      result.out_x == 16'd0 && result.out_y == 16'd0 && result.out_z == 16'd0)
    else $error("zero norm without identity");

  a_unit_nonzero: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.zero_norm |->
      (result.out_w | result.out_x | result.out_y | result.out_z) != 16'd0)
    else $error("normalized item is all zero");

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import qpn_pkg::*;

  typedef struct {
    logic [15:0] w;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] z;
    logic        zn;
  } unit_quat_t;

  class prop_scoreboard;
    longint     period;
    longint     noise[4];
    unit_quat_t pending[$];
    int         errors;

    function new();
      period = 10;
      foreach (noise[i]) noise[i] = 0;
      errors = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [31:0] v);
      case (idx)
        REG_PERIOD:  period = v[9:0];
        REG_NOISE_W: noise[0] = $signed(v[15:0]);
        REG_NOISE_X: noise[1] = $signed(v[15:0]);
        REG_NOISE_Y: noise[2] = $signed(v[15:0]);
        REG_NOISE_Z: noise[3] = $signed(v[15:0]);
        default: ;
      endcase
    endfunction

    function longint unsigned isqrt(longint unsigned n);
      longint unsigned res;
      longint unsigned bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
        if (n >= res + bitv) begin
          n -= res + bitv;
          res = (res >> 1) + bitv;
        end else begin
          res >>= 1;
        end
        bitv >>= 2;
      end
      return res;
    endfunction

    function longint sat16(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
    endfunction

    function void note_sample(logic [15:0] qw, qx, qy, qz, rx, ry, rz);
      longint q[4], r[3], s[4], p[4], o[4];
      longint mag, inc, den;
      longint unsigned n2, nrm, num, qq;
      unit_quat_t e;
      q[0] = $signed(qw); q[1] = $signed(qx); q[2] = $signed(qy); q[3] = $signed(qz);
      r[0] = $signed(rx); r[1] = $signed(ry); r[2] = $signed(rz);
      s[0] = -r[0] * q[1] - r[1] * q[2] - r[2] * q[3];
      s[1] =  r[0] * q[0] + r[2] * q[2] - r[1] * q[3];
      s[2] =  r[1] * q[0] - r[2] * q[1] + r[0] * q[3];
      s[3] =  r[2] * q[0] + r[1] * q[1] - r[0] * q[2];
      den = 2000 * 1024;
      n2 = 0;
      for (int i = 0; i < 4; i++) begin
        inc = s[i] * period;
        mag = (inc < 0) ? -inc : inc;
        mag = (2 * mag + den) / (2 * den);
        inc = (inc < 0) ? -mag : mag;
        p[i] = sat16(q[i] + inc + noise[i]);
        n2 += p[i] * p[i];
      end
      if (n2 == 0) begin
        o[0] = sat16(longint'(1) << 14);
        o[1] = 0; o[2] = 0; o[3] = 0;
      end else begin
        nrm = isqrt(n2 << 28);
        for (int i = 0; i < 4; i++) begin
          mag = (p[i] < 0) ? -p[i] : p[i];
          num = longint'(mag) << 28;
          qq = (2 * num + nrm) / (2 * nrm);
          if (qq > 32768) qq = 32768;
          o[i] = sat16((p[i] < 0) ? -longint'(qq) : longint'(qq));
        end
      end
      e.w = o[0][15:0]; e.x = o[1][15:0]; e.y = o[2][15:0]; e.z = o[3][15:0];
      e.zn = (n2 == 0);
      pending.push_back(e);
    endfunction

    function void report(string what, logic [15:0] got, logic [15:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
      errors++;
    endfunction

    function void check_result(logic [15:0] ow, ox, oy, oz, logic zn);
      unit_quat_t e;
      if (pending.size() == 0) begin
        report("unexpected result", ow, 16'h0);
        return;
      end
      e = pending.pop_front();
      if (ow !== e.w) report("out_w", ow, e.w);
      if (ox !== e.x) report("out_x", ox, e.x);
      if (oy !== e.y) report("out_y", oy, e.y);
      if (oz !== e.z) report("out_z", oz, e.z);
      if (zn !== e.zn) report("zero_norm", {15'd0, zn}, {15'd0, e.zn});
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  qpn_in_if  sample();
  qpn_out_if result();

  quaternion_propagate_normalize u_top (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .sample(sample.sink), .result(result.source)
  );

  prop_scoreboard sb = new();
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_seq = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  always #6 clk = ~clk;

  initial begin
    sample.valid = 1'b0;
    sample.quat_w = '0; sample.quat_x = '0; sample.quat_y = '0; sample.quat_z = '0;
    sample.rate_x = '0; sample.rate_y = '0; sample.rate_z = '0;
    result.ready = 1'b0;
  end

  always @(posedge clk) begin
    if (sample.valid && sample.ready)
      sb.note_sample(sample.quat_w, sample.quat_x, sample.quat_y, sample.quat_z,
                     sample.rate_x, sample.rate_y, sample.rate_z);
    if (!rst && result.valid && result.ready)
      sb.check_result(result.out_w, result.out_x, result.out_y, result.out_z,
                      result.zero_norm);
  end

  // receiver: random stalls, plus a long hold-off when requested
  always @(posedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      hold_left--;
      result.ready <= 1'b0;
    end else begin
      result.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if ((sample.valid && sample.ready) || (result.valid && result.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= 20000) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic write_reg(reg_idx_t idx, logic [31:0] v);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 5'(idx) << 2; pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    sb.set_reg(idx, v);
  endtask

  task automatic send_sample(logic [15:0] qw, qx, qy, qz, rx, ry, rz);
    if ($urandom_range(99) < tx_idle_pct) begin
      // drop valid right at the accepting edge, then idle
      sample.valid <= 1'b0;
      repeat (1 + $urandom_range(2)) @(posedge clk);
    end else if (!sample.valid) begin
      @(posedge clk);
    end
    sample.valid <= 1'b1;
    sample.quat_w <= qw; sample.quat_x <= qx; sample.quat_y <= qy; sample.quat_z <= qz;
    sample.rate_x <= rx; sample.rate_y <= ry; sample.rate_z <= rz;
    @(posedge clk);
    while (!sample.ready) @(posedge clk);
  endtask

  task automatic drain();
    sample.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic send_random(int count);
    logic [15:0] f[7];
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(3) == 0) begin
        foreach (f[i]) f[i] = 16'($urandom);
      end else begin
        for (int i = 0; i < 4; i++) f[i] = 16'($signed($urandom_range(23170)) - 11585);
        for (int i = 4; i < 7; i++) f[i] = 16'($signed($urandom_range(8191)) - 4096);
      end
      send_sample(f[0], f[1], f[2], f[3], f[4], f[5], f[6]);
    end
  endtask

  task automatic random_noise();
    write_reg(REG_NOISE_W, {16'd0, 16'($signed($urandom_range(1023)) - 512)});
    write_reg(REG_NOISE_X, {16'd0, 16'($signed($urandom_range(1023)) - 512)});
    write_reg(REG_NOISE_Y, {16'd0, 16'($signed($urandom_range(1023)) - 512)});
    write_reg(REG_NOISE_Z, {16'd0, 16'($signed($urandom_range(1023)) - 512)});
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    // directed: extremes, zero norm, identity, saturation
    send_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h7fff, 16'h8000, 16'h7fff);
    send_sample(16'h4000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_sample(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    send_sample(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_sample(16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h8000);
    send_sample(16'h0001, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_sample(16'hffff, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_sample(16'h0000, 16'h8000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_sample(16'h2d41, 16'h2d41, 16'h0000, 16'h0000, 16'h0400, 16'hfc00, 16'h0400);
    drain();
    write_reg(REG_PERIOD, 32'd1023);
    send_sample(16'h7fff, 16'h0000, 16'h0000, 16'h0000, 16'h7fff, 16'h7fff, 16'h7fff);
    send_sample(16'h4000, 16'h4000, 16'h4000, 16'h4000, 16'h8000, 16'h8000, 16'h8000);
    send_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h1234, 16'h0000, 16'h0000);
    drain();
    write_reg(REG_PERIOD, 32'd0);
    write_reg(REG_NOISE_W, 32'h0000_8000);
    write_reg(REG_NOISE_X, 32'h0000_7fff);
    write_reg(REG_NOISE_Y, 32'h0000_8000);
    write_reg(REG_NOISE_Z, 32'h0000_7fff);
    send_sample(16'h8000, 16'h7fff, 16'h0000, 16'h0000, 16'h7fff, 16'h0000, 16'h0000);
    send_sample(16'h0000, 16'h8001, 16'h8000, 16'h8000, 16'h0000, 16'h0000, 16'h0000);
    drain();
    // noise cancels the quaternion: zero norm again
    write_reg(REG_NOISE_W, 32'h0000_c000);
    write_reg(REG_NOISE_X, 32'h0000_0000);
    write_reg(REG_NOISE_Y, 32'h0000_0000);
    write_reg(REG_NOISE_Z, 32'h0000_0000);
    send_sample(16'h4000, 16'h0000, 16'h0000, 16'h0000, 16'h7fff, 16'h7fff, 16'h7fff);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0, 1: begin tx_idle_pct = 14; rx_idle_pct = 55; end
        2, 3: begin tx_idle_pct = 55; rx_idle_pct = 14; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      case (ph)
        0: write_reg(REG_PERIOD, 32'd10);
        1: write_reg(REG_PERIOD, 32'd1000);
        2: write_reg(REG_PERIOD, 32'd1);
        3: write_reg(REG_PERIOD, 32'd1023);
        default: write_reg(REG_PERIOD, $urandom_range(1023));
      endcase
      if (ph == 0) begin
        write_reg(REG_NOISE_W, 32'd0);
        write_reg(REG_NOISE_X, 32'd0);
        write_reg(REG_NOISE_Y, 32'd0);
        write_reg(REG_NOISE_Z, 32'd0);
      end else begin
        random_noise();
      end
      // hold off the receiver while items keep coming
      if (ph == 1) hold_seq++;
      send_random(175);
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/qpn_pkg.sv
hdl/qpn_in_if.sv
hdl/qpn_out_if.sv
hdl/qpn_prop.sv
hdl/qpn_norm.sv
hdl/qpn_div.sv
hdl/quaternion_propagate_normalize.sv
dv/testbench.sv
